// ===== design/kntlex_pkg.sv =====
// Shared constants, token record type and character-class functions for the lexer.
package kntlex_pkg;

    localparam int MAX_TEXT_BYTES = 65536;
    localparam int POS_W          = $clog2(MAX_TEXT_BYTES);
    localparam int TOK_W          = 16;
    localparam int MAX_RES        = 3;
    localparam int FIFO_DEPTH     = 4;
    localparam int PTR_W          = $clog2(FIFO_DEPTH);
    localparam int CNT_W          = $clog2(FIFO_DEPTH + 1);
    localparam int DECL_LEN       = 11;
    localparam int INT_LEN        = 7;

    localparam logic [3:0] KIND_IDENT   = 4'd10;
    localparam logic [3:0] KIND_DECL    = 4'd11;
    localparam logic [3:0] KIND_INTEGER = 4'd12;
    localparam logic [3:0] KIND_NUMBER  = 4'd13;
    localparam logic [3:0] KIND_END     = 4'd14;
    localparam logic [3:0] KIND_ERROR   = 4'd15;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    typedef struct packed {
        logic [3:0]       kind;
        logic [TOK_W-1:0] start;
        logic [TOK_W-1:0] length;
        logic [TOK_W-1:0] line;
        logic             last;
    } t_tok;

    function automatic logic is_word(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // {hit, code}
    function automatic logic [4:0] punct_code(input logic [7:0] c);
        logic [4:0] r;
        unique case (c)
            "(":     r = {1'b1, 4'd0};
            ")":     r = {1'b1, 4'd1};
            "{":     r = {1'b1, 4'd2};
            "}":     r = {1'b1, 4'd3};
            ",":     r = {1'b1, 4'd4};
            ":":     r = {1'b1, 4'd5};
            "+":     r = {1'b1, 4'd6};
            "-":     r = {1'b1, 4'd7};
            "/":     r = {1'b1, 4'd8};
            "*":     r = {1'b1, 4'd9};
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kw_decl_char(input logic [3:0] i);
        logic [7:0] r;
        unique case (i)
            4'd0:    r = "d";
            4'd1:    r = "e";
            4'd2:    r = "c";
            4'd3:    r = "l";
            4'd4:    r = "a";
            4'd5:    r = "r";
            4'd6:    r = "a";
            4'd7:    r = "t";
            4'd8:    r = "i";
            4'd9:    r = "o";
            4'd10:   r = "n";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kw_int_char(input logic [2:0] i);
        logic [7:0] r;
        unique case (i)
            3'd0:    r = "i";
            3'd1:    r = "n";
            3'd2:    r = "t";
            3'd3:    r = "e";
            3'd4:    r = "g";
            3'd5:    r = "e";
            3'd6:    r = "r";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// ===== design/keyword_number_token_lexer_top.sv =====
// Byte-stream lexer: tokenizes source text into kind, start, length and line records.
// One input byte is taken per cycle and scanned in a single pass against the held
// token state; the zero to three tokens it closes are written at once into a
// four-entry result queue that drains one token per cycle while i_stall is low. Input
// stalls only while the queue holds more than one token, so bytes that give at most
// one token flow at one per cycle when i_stall is low, and the tokens of one byte
// leave in turn. The final_byte flag flushes any open token, adds an end token and
// restarts offsets and the line count for the next text. Ready at once after reset.
module keyword_number_token_lexer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_final_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_token_kind,
    output logic [15:0] o_token_start,
    output logic [15:0] o_token_length,
    output logic [15:0] o_token_line,
    output logic        o_run_last
);
    import kntlex_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUM,
        MODE_ERR
    } t_mode;

    t_mode            r_mode,  n_mode;
    logic [POS_W-1:0] r_pos,   n_pos;
    logic [POS_W-1:0] r_start, n_start;
    logic [TOK_W-1:0] r_line,  n_line;
    logic [TOK_W-1:0] r_tline, n_tline;
    logic [1:0]       r_flags, n_flags;

    t_tok             r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;

    t_tok             n_tok [MAX_RES];
    logic [1:0]       n_num;

    logic in_xfer, out_xfer;

    assign o_stall  = r_cnt > CNT_W'(FIFO_DEPTH - MAX_RES);
    assign in_xfer  = i_valid && !o_stall;
    assign o_valid  = r_cnt != '0;
    assign out_xfer = o_valid && !i_stall;

    assign o_token_kind   = r_fifo[r_rp].kind;
    assign o_token_start  = r_fifo[r_rp].start;
    assign o_token_length = r_fifo[r_rp].length;
    assign o_token_line   = r_fifo[r_rp].line;
    assign o_run_last     = r_fifo[r_rp].last;

    function automatic logic [1:0] match_kw(input logic [1:0] f, input logic [7:0] c,
                                            input logic [POS_W-1:0] i);
        logic [1:0] r;
        r = f;
        if (i >= POS_W'(DECL_LEN) || c != kw_decl_char(4'(i))) begin
            r[0] = 1'b0;
        end
        if (i >= POS_W'(INT_LEN) || c != kw_int_char(3'(i))) begin
            r[1] = 1'b0;
        end
        return r;
    endfunction

    function automatic t_tok close_tok(input t_mode m, input logic [1:0] f,
                                       input logic [POS_W-1:0] s,
                                       input logic [POS_W-1:0] len,
                                       input logic [TOK_W-1:0] tl);
        t_tok t;
        t.kind = KIND_NUMBER;
        if (m == MODE_IDENT) begin
            if (len == POS_W'(DECL_LEN) && f[0]) begin
                t.kind = KIND_DECL;
            end else if (len == POS_W'(INT_LEN) && f[1]) begin
                t.kind = KIND_INTEGER;
            end else begin
                t.kind = KIND_IDENT;
            end
        end
        t.start  = TOK_W'(s);
        t.length = TOK_W'(len);
        t.line   = tl;
        t.last   = 1'b0;
        return t;
    endfunction

    always_comb begin
        logic [4:0]       pc;
        logic [POS_W-1:0] end_pos;
        t_tok             t;
        t       = '0;
        pc      = punct_code(i_text_byte);
        end_pos = r_pos + POS_W'(1);
        n_mode  = r_mode;
        n_pos   = r_pos;
        n_start = r_start;
        n_line  = r_line;
        n_tline = r_tline;
        n_flags = r_flags;
        n_num   = 2'd0;
        for (int k = 0; k < MAX_RES; k++) begin
            n_tok[k] = '0;
        end

        if ((r_mode == MODE_IDENT && !is_word(i_text_byte)) ||
            (r_mode == MODE_NUM && !is_digit(i_text_byte))) begin
            n_tok[n_num] = close_tok(r_mode, r_flags, r_start, r_pos - r_start, r_tline);
            n_num        = n_num + 2'd1;
            n_mode       = MODE_IDLE;
        end

        if (n_mode == MODE_IDENT) begin
            n_flags = match_kw(r_flags, i_text_byte, r_pos - r_start);
        end else if (n_mode == MODE_IDLE) begin
            if (pc[4]) begin
                t.kind   = pc[3:0];
                t.start  = TOK_W'(r_pos);
                t.length = TOK_W'(1);
                t.line   = r_line;
                t.last   = 1'b0;
                n_tok[n_num] = t;
                n_num        = n_num + 2'd1;
            end else if (i_text_byte == CH_SPACE || i_text_byte == CH_TAB) begin
                n_mode = MODE_IDLE;
            end else if (i_text_byte == CH_NEWLINE) begin
                if (r_line != '1) begin
                    n_line = r_line + TOK_W'(1);
                end
            end else if (is_word(i_text_byte)) begin
                n_mode  = MODE_IDENT;
                n_start = r_pos;
                n_tline = r_line;
                n_flags = match_kw(2'b11, i_text_byte, '0);
            end else if (is_digit(i_text_byte)) begin
                n_mode  = MODE_NUM;
                n_start = r_pos;
                n_tline = r_line;
                n_flags = 2'b11;
            end else begin
                t.kind   = KIND_ERROR;
                t.start  = TOK_W'(r_pos);
                t.length = TOK_W'(1);
                t.line   = r_line;
                t.last   = 1'b0;
                n_tok[n_num] = t;
                n_num        = n_num + 2'd1;
                n_mode       = MODE_ERR;
            end
        end

        if (i_final_byte) begin
            if (n_mode == MODE_IDENT || n_mode == MODE_NUM) begin
                n_tok[n_num] = close_tok(n_mode, n_flags, n_start, end_pos - n_start,
                                         n_tline);
                n_num        = n_num + 2'd1;
            end
            t.kind   = KIND_END;
            t.start  = TOK_W'(end_pos);
            t.length = '0;
            t.line   = n_line;
            t.last   = 1'b0;
            n_tok[n_num] = t;
            n_num        = n_num + 2'd1;
            n_mode  = MODE_IDLE;
            n_pos   = '0;
            n_start = '0;
            n_line  = '0;
            n_tline = '0;
            n_flags = 2'b11;
        end else begin
            n_pos = end_pos;
        end

        if (n_num != 2'd0) begin
            n_tok[n_num - 2'd1].last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_pos   <= '0;
            r_start <= '0;
            r_line  <= '0;
            r_tline <= '0;
            r_flags <= 2'b11;
        end else if (in_xfer) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_line  <= n_line;
            r_tline <= n_tline;
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            for (int k = 0; k < MAX_RES; k++) begin
                if (2'(k) < n_num) begin
                    r_fifo[r_wp + PTR_W'(k)] <= n_tok[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (in_xfer) begin
                r_wp <= r_wp + PTR_W'(n_num);
            end
            if (out_xfer) begin
                r_rp <= r_rp + PTR_W'(1);
            end
            r_cnt <= r_cnt + (in_xfer ? CNT_W'(n_num) : '0) - (out_xfer ? CNT_W'(1) : '0);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_final_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_final_byte |=> r_mode == MODE_IDLE && r_pos == '0 && r_line == '0)
        else $error("state not restarted after final byte");

    a_final_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_final_byte |-> n_num != 2'd0 && n_tok[n_num - 2'd1].kind == KIND_END)
        else $error("final byte without end token");

    a_line_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_xfer && i_final_byte) |=> r_line >= $past(r_line))
        else $error("line count moved backward");

    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && !i_final_byte |=> r_pos == $past(r_pos) + POS_W'(1))
        else $error("byte offset did not advance");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the keyword/number token lexer: random text, token predictor, scoreboard.
package lexer_bench_pkg;
    import kntlex_pkg::*;

    class token_scoreboard;
        typedef enum logic [1:0] {SCAN_GAP, SCAN_WORD, SCAN_NUMBER, SCAN_DROP} t_scan;

        string       decl_word   = "declaration";
        string       int_word    = "integer";
        string       punct_chars = "(){},:+-/*";
        t_scan       mode;
        int unsigned pos;
        int unsigned tok_start;
        int unsigned line;
        int unsigned tok_line;
        bit          decl_ok;
        bit          int_ok;
        t_tok        expected_tokens[$];
        int          mismatch_count;

        function new();
            mismatch_count = 0;
            clear();
        endfunction

        function void clear();
            mode      = SCAN_GAP;
            pos       = 0;
            tok_start = 0;
            line      = 0;
            tok_line  = 0;
            decl_ok   = 1'b1;
            int_ok    = 1'b1;
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
        endfunction

        function bit is_numeral(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function int punct_index(logic [7:0] c);
            foreach (punct_chars[i])
                if (punct_chars[i] == c)
                    return i;
            return -1;
        endfunction

        function void push(logic [3:0] kind, int unsigned start, int unsigned len,
                           int unsigned ln);
            t_tok t;
            t.kind   = kind;
            t.start  = TOK_W'(start);
            t.length = TOK_W'(len);
            t.line   = TOK_W'(ln);
            t.last   = 1'b0;
            expected_tokens.push_back(t);
        endfunction

        function void track_keyword(logic [7:0] c);
            int unsigned i;
            i = (pos + MAX_TEXT_BYTES - tok_start) % MAX_TEXT_BYTES;
            if (i >= DECL_LEN || c != decl_word[i])
                decl_ok = 1'b0;
            if (i >= INT_LEN || c != int_word[i])
                int_ok = 1'b0;
        endfunction

        function void open_token(t_scan m);
            mode      = m;
            tok_start = pos;
            tok_line  = line;
            decl_ok   = 1'b1;
            int_ok    = 1'b1;
        endfunction

        function void close_token(int unsigned stop);
            int unsigned len;
            logic [3:0]  kind;
            len  = (stop + MAX_TEXT_BYTES - tok_start) % MAX_TEXT_BYTES;
            kind = KIND_NUMBER;
            if (mode == SCAN_WORD) begin
                if (len == DECL_LEN && decl_ok)
                    kind = KIND_DECL;
                else if (len == INT_LEN && int_ok)
                    kind = KIND_INTEGER;
                else
                    kind = KIND_IDENT;
            end
            push(kind, tok_start, len, tok_line);
            mode = SCAN_GAP;
        endfunction

        function void note_byte(logic [7:0] c, logic fin);
            int          first;
            int          k;
            int unsigned stop;
            t_tok        t;
            first = expected_tokens.size();
            if ((mode == SCAN_WORD && !is_letter(c)) || (mode == SCAN_NUMBER && !is_numeral(c)))
                close_token(pos);
            if (mode == SCAN_WORD) begin
                track_keyword(c);
            end else if (mode == SCAN_GAP) begin
                k = punct_index(c);
                if (k >= 0) begin
                    push(4'(k), pos, 1, line);
                end else if (c == CH_NEWLINE) begin
                    if (line < 65535)
                        line++;
                end else if (is_letter(c)) begin
                    open_token(SCAN_WORD);
                    track_keyword(c);
                end else if (is_numeral(c)) begin
                    open_token(SCAN_NUMBER);
                end else if (c != CH_SPACE && c != CH_TAB) begin
                    push(KIND_ERROR, pos, 1, line);
                    mode = SCAN_DROP;
                end
            end
            if (fin) begin
                stop = (pos + 1) % MAX_TEXT_BYTES;
                if (mode == SCAN_WORD || mode == SCAN_NUMBER)
                    close_token(stop);
                push(KIND_END, stop, 0, line);
                clear();
            end else begin
                pos = (pos + 1) % MAX_TEXT_BYTES;
            end
            if (expected_tokens.size() > first) begin
                t = expected_tokens.pop_back();
                t.last = 1'b1;
                expected_tokens.push_back(t);
            end
        endfunction

        function string show(t_tok t);
            return $sformatf("kind=%0d start=%0d length=%0d line=%0d last=%0b",
                             t.kind, t.start, t.length, t.line, t.last);
        endfunction

        function void report(string s);
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%s", s);
        endfunction

        function void check_token(t_tok got);
            t_tok exp;
            if (expected_tokens.size() == 0) begin
                report({"unexpected token: ", show(got)});
                return;
            end
            exp = expected_tokens.pop_front();
            if (got.kind !== exp.kind || got.start !== exp.start || got.length !== exp.length ||
                got.line !== exp.line || got.last !== exp.last)
                report({"token mismatch: expected ", show(exp), ", got ", show(got)});
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction

        function void flush_missing();
            t_tok exp;
            while (expected_tokens.size() != 0) begin
                exp = expected_tokens.pop_front();
                report({"missing token: ", show(exp)});
            end
        endfunction
    endclass
endpackage

module testbench;
    import kntlex_pkg::*;
    import lexer_bench_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_text_byte;
    logic        i_final_byte;
    logic        o_valid;
    logic        i_stall;
    logic [3:0]  o_token_kind;
    logic [15:0] o_token_start;
    logic [15:0] o_token_length;
    logic [15:0] o_token_line;
    logic        o_run_last;

    token_scoreboard sb;
    bit              steady;
    int              random_bytes;
    logic [7:0]      text_q[$];
    string           punct_pool = "(){},:+-/*";
    string           word_pool[12] = '{"declaration", "integer", "declarations", "integers",
                                       "declaratio", "intege", "Integer", "int", "d",
                                       "decl_aration", "integerinteger", "DECLARATION"};

    keyword_number_token_lexer_top dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #12_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_byte(input logic [7:0] c, input logic fin);
        while (!steady && $urandom_range(99) < 23) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_text_byte  <= c;
        i_final_byte <= fin;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        sb.note_byte(c, fin);
    endtask

    task automatic send_text();
        foreach (text_q[i])
            send_byte(text_q[i], i == text_q.size() - 1);
        text_q.delete();
    endtask

    function automatic void add_str(string s);
        foreach (s[i])
            text_q.push_back(s[i]);
    endfunction

    function automatic logic [7:0] rand_letter();
        int k;
        k = $urandom_range(52);
        if (k < 26)
            return 8'("a" + k);
        if (k < 52)
            return 8'("A" + k - 26);
        return "_";
    endfunction

    function automatic logic [7:0] rand_space();
        case ($urandom_range(2))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            default: return CH_NEWLINE;
        endcase
    endfunction

    function automatic void add_piece();
        case ($urandom_range(9))
            0, 1: add_str(word_pool[$urandom_range(11)]);
            2, 3: repeat ($urandom_range(1, 12)) text_q.push_back(rand_letter());
            4: repeat ($urandom_range(1, 6)) text_q.push_back(8'("0" + $urandom_range(9)));
            5, 6: text_q.push_back(punct_pool[$urandom_range(9)]);
            7, 8: repeat ($urandom_range(1, 3)) text_q.push_back(rand_space());
            default: begin
                if ($urandom_range(2) == 0)
                    text_q.push_back(8'($urandom_range(255)));
                else
                    text_q.push_back(CH_SPACE);
            end
        endcase
    endfunction

    // receiving side: random stalls plus one long hold-off to back up the result queue
    initial begin : token_sink
        int   n_seen;
        int   hold;
        t_tok got;
        n_seen = 0;
        hold   = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got.kind   = o_token_kind;
                got.start  = o_token_start;
                got.length = o_token_length;
                got.line   = o_token_line;
                got.last   = o_run_last;
                sb.check_token(got);
                n_seen++;
                if (n_seen == 40)
                    hold = 150;
            end
            if (hold > 0) begin
                hold--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !steady && $urandom_range(99) < 23;
            end
        end
    end

    initial begin
        sb           = new();
        steady       = 1'b0;
        random_bytes = 0;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_text_byte  <= 8'h00;
        i_final_byte <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_str("(){},:+-/*");
        send_text();
        add_str("ab1 9Z\n");
        send_text();
        text_q.push_back(8'h00);
        text_q.push_back(8'hFF);
        send_text();
        add_str("_");
        send_text();
        add_str("integer");
        send_text();

        add_str("abcdef");
        repeat (10) text_q.push_back(CH_NEWLINE);
        add_str("7");
        send_text();

        while (random_bytes < 170) begin
            steady = random_bytes >= 80 && random_bytes < 130;
            repeat ($urandom_range(1, 8)) add_piece();
            random_bytes += text_q.size();
            send_text();
        end
        steady = 1'b0;
        i_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        sb.flush_missing();
        if (sb.mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
